FILE: hdl/rbd_pkg.sv
// Shared types and field widths for the running balance drawdown tracker.
`default_nettype none

package rbd_pkg;

	localparam int CHANGE_W  = 10;
	localparam int BALANCE_W = 48;
	localparam int HIGHEST_W = 47;
	localparam int DROP_W    = 48;
	localparam int STEP_W    = 32;
	// width used to extend internal values before trimming to a field
	localparam int WIDE_W    = 64;

	typedef struct packed {
		logic signed [CHANGE_W-1:0] change;
	} rbd_item_t;

	typedef struct packed {
		logic signed [BALANCE_W-1:0] balance;
		logic signed [BALANCE_W-1:0] lowest;
		logic [STEP_W-1:0]           lowest_step;
		logic [HIGHEST_W-1:0]        highest;
		logic [STEP_W-1:0]           highest_step;
		logic [DROP_W-1:0]           worst_drop;
		logic [STEP_W-1:0]           drop_start;
		logic [STEP_W-1:0]           drop_end;
		logic [STEP_W-1:0]           step_number;
	} rbd_result_t;

endpackage

`default_nettype wire

FILE: hdl/rbd_stream_if.sv
// Valid/ready stream channel carrying one request payload.
`default_nettype none

interface rbd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hdl/running_balance_drawdown_tracker_core.sv
// Running balance and drawdown tracker: input register, tracker, result register.
//
// Use: each request on the item channel carries a signed 10-bit change. The
// block adds it to a running balance, counts the step (from 1, saturating),
// and keeps the lowest and highest prefix balance with their first steps,
// plus the worst fall from a running peak with its peak and end steps.
// Every request yields exactly one request on the result channel that
// reports the whole state after that step.
// Flow: an accepted request is held in the input register, and its result
// is then registered in the result register. Throughput: one request per
// cycle while results are taken, since the balance add, compare and drop
// update feed the state registers back into themselves combinationally.
// Reset: arst_n clears all state to zero (balance, extremes, drop, step
// count) and empties both pipeline stages.
// Stall: while a result waits unaccepted, the input register can still take
// one request; after that item.ready drops until the result is taken.
`default_nettype none

module running_balance_drawdown_tracker_core
	import rbd_pkg::*;
#(
	parameter int STEP_BITS    = 32,
	parameter int BALANCE_BITS = 48
) (
	input wire logic    clk,
	input wire logic    arst_n,
	rbd_stream_if.sink  item,
	rbd_stream_if.source result
);

	logic                       valid_s1;
	logic signed [CHANGE_W-1:0] change_s1;
	logic                       valid_s2;
	rbd_result_t                res_s2;
	rbd_result_t                next_res;
	logic                       advance;
	logic                       take_in;

	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign take_in    = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			change_s1 <= item.payload.change;
		end
		if (advance) begin
			res_s2 <= next_res;
		end
	end

	rbd_track #(
		.STEP_BITS    (STEP_BITS),
		.BALANCE_BITS (BALANCE_BITS)
	) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.change   (change_s1),
		.next_res (next_res)
	);

	assign result.valid   = valid_s2;
	assign result.payload = res_s2;

endmodule

`default_nettype wire

FILE: hdl/rbd_track.sv
// Tracker state registers and the combinational next-state datapath.
`default_nettype none

module rbd_track
	import rbd_pkg::*;
#(
	parameter int STEP_BITS    = 32,
	parameter int BALANCE_BITS = 48
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       advance,
	input  wire logic signed [CHANGE_W-1:0] change,
	output rbd_result_t                     next_res
);

	localparam logic [STEP_BITS-1:0] STEP_MAX = {STEP_BITS{1'b1}};
	localparam logic signed [BALANCE_BITS-1:0] BAL_MAX = {1'b0, {(BALANCE_BITS-1){1'b1}}};
	localparam logic signed [BALANCE_BITS-1:0] BAL_MIN = {1'b1, {(BALANCE_BITS-1){1'b0}}};

	logic signed [BALANCE_BITS-1:0] total_q, min_q, max_q;
	logic [BALANCE_BITS-1:0]        drop_q;
	logic [STEP_BITS-1:0]           step_q, min_step_q, max_step_q, drop_from_q, drop_to_q;

	logic [STEP_BITS-1:0]           step_nx, min_step_nx, max_step_nx, drop_from_nx, drop_to_nx;
	logic signed [BALANCE_BITS:0]   sum;
	logic signed [BALANCE_BITS-1:0] total_nx, min_nx, max_nx, diff;
	logic [BALANCE_BITS-1:0]        loss, drop_nx;
	logic                           new_min, new_max, take_drop;

	logic signed [WIDE_W-1:0] total_w, min_w;
	logic [WIDE_W-1:0]        max_w, drop_w;
	logic [WIDE_W-1:0]        step_w, min_step_w, max_step_w, from_w, to_w;

	always_comb begin
		step_nx = (step_q == STEP_MAX) ? step_q : step_q + 1'b1;

		// add with one guard bit, clamp on overflow
		sum = (BALANCE_BITS+1)'(total_q) + (BALANCE_BITS+1)'(change);
		if (sum[BALANCE_BITS] != sum[BALANCE_BITS-1]) begin
			total_nx = sum[BALANCE_BITS] ? BAL_MIN : BAL_MAX;
		end else begin
			total_nx = sum[BALANCE_BITS-1:0];
		end

		new_min     = total_nx < min_q;
		min_nx      = new_min ? total_nx : min_q;
		min_step_nx = new_min ? step_nx : min_step_q;

		new_max     = total_nx > max_q;
		max_nx      = new_max ? total_nx : max_q;
		max_step_nx = new_max ? step_nx : max_step_q;

		// fall from the peak; zero when this step sets a new peak
		diff = max_q - total_nx;
		loss = new_max ? '0 : diff;

		take_drop = (loss > drop_q) ||
			((loss == drop_q) &&
			 ((max_step_nx < drop_from_q) ||
			  ((max_step_nx == drop_from_q) && (step_nx < drop_to_q))));
		drop_nx      = take_drop ? loss : drop_q;
		drop_from_nx = take_drop ? max_step_nx : drop_from_q;
		drop_to_nx   = take_drop ? step_nx : drop_to_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			total_q     <= '0;
			min_q       <= '0;
			min_step_q  <= '0;
			max_q       <= '0;
			max_step_q  <= '0;
			drop_q      <= '0;
			drop_from_q <= '0;
			drop_to_q   <= '0;
		end else if (advance) begin
			step_q      <= step_nx;
			total_q     <= total_nx;
			min_q       <= min_nx;
			min_step_q  <= min_step_nx;
			max_q       <= max_nx;
			max_step_q  <= max_step_nx;
			drop_q      <= drop_nx;
			drop_from_q <= drop_from_nx;
			drop_to_q   <= drop_to_nx;
		end
	end

	// extend to a common width, then trim to the result fields
	always_comb begin
		total_w    = WIDE_W'(total_nx);
		min_w      = WIDE_W'(min_nx);
		max_w      = WIDE_W'($unsigned(max_nx));
		drop_w     = WIDE_W'(drop_nx);
		step_w     = WIDE_W'(step_nx);
		min_step_w = WIDE_W'(min_step_nx);
		max_step_w = WIDE_W'(max_step_nx);
		from_w     = WIDE_W'(drop_from_nx);
		to_w       = WIDE_W'(drop_to_nx);

		next_res.balance      = total_w[BALANCE_W-1:0];
		next_res.lowest       = min_w[BALANCE_W-1:0];
		next_res.lowest_step  = min_step_w[STEP_W-1:0];
		next_res.highest      = max_w[HIGHEST_W-1:0];
		next_res.highest_step = max_step_w[STEP_W-1:0];
		next_res.worst_drop   = drop_w[DROP_W-1:0];
		next_res.drop_start   = from_w[STEP_W-1:0];
		next_res.drop_end     = to_w[STEP_W-1:0];
		next_res.step_number  = step_w[STEP_W-1:0];
	end

endmodule

`default_nettype wire

FILE: hdl/rbd_checker.sv
// Port-level checks for the tracker core and the bind that attaches them.
`default_nettype none

module rbd_checker
	import rbd_pkg::*;
#(
	parameter int STEP_BITS = 32
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire rbd_result_t out_res
);

	localparam logic [WIDE_W-1:0] STEP_TOP = WIDE_W'({STEP_BITS{1'b1}});
	localparam logic [STEP_W-1:0] STEP_SAT = STEP_TOP[STEP_W-1:0];

	logic [STEP_W-1:0] last_step_q;
	logic [DROP_W-1:0] last_drop_q;

	// hold the fields of the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_step_q <= '0;
			last_drop_q <= '0;
		end else if (out_valid && out_ready) begin
			last_step_q <= out_res.step_number;
			last_drop_q <= out_res.worst_drop;
		end
	end

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped before it was taken");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_res))
		else $error("result payload changed while stalled");

	a_step_advances: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_res.step_number == last_step_q + 1'b1) ||
			(last_step_q == STEP_SAT && out_res.step_number == STEP_SAT))
		else $error("step number did not advance by one per result");

	a_drop_grows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_res.worst_drop >= last_drop_q)
		else $error("worst drop shrank between results");

endmodule

bind running_balance_drawdown_tracker_core rbd_checker #(
	.STEP_BITS (STEP_BITS)
) u_rbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_res   (result.payload)
);

`default_nettype wire
